// ===== rtl/qdv_pkg.sv =====
// Shared types and constants of the quadrature decoder with velocity.
package qdv_pkg;

    typedef logic [1:0] t_step;    // 2'b00 no move, 2'b01 +1, 2'b11 -1

    localparam t_step STEP_NONE = 2'b00;
    localparam t_step STEP_FWD  = 2'b01;
    localparam t_step STEP_REV  = 2'b11;

    // x4 decode, indexed by {previous phase, current phase}, phase = {B, A}
    localparam t_step STEP_TBL [0:15] = '{
        STEP_NONE, STEP_REV,  STEP_FWD,  STEP_NONE,
        STEP_FWD,  STEP_NONE, STEP_NONE, STEP_REV,
        STEP_REV,  STEP_NONE, STEP_NONE, STEP_FWD,
        STEP_NONE, STEP_FWD,  STEP_REV,  STEP_NONE
    };

    localparam int          CFG_IDX_W   = 8;
    localparam logic [7:0]  CFG_PITCH   = 8'd0;
    localparam logic [7:0]  CFG_CPU     = 8'd1;

    localparam logic [31:0] PITCH_RST   = 32'd65536;
    localparam logic [15:0] CPU_RST     = 16'd1024;
    localparam logic [31:0] WINDOW_MS   = 32'd1000;

    // quotient bits kept by the divider; anything above folds into overflow
    localparam int          QW          = 33;

endpackage

// ===== rtl/qdv_track.sv =====
// Phase decoder, position counter, sample ring with running sums, frequency window.
module qdv_track #(
    parameter int RING_DEPTH = 8,
    parameter int SSW        = 6,
    parameter int ISW        = 36
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic                  i_phase_a,
    input  logic                  i_phase_b,
    input  logic [31:0]           i_now,
    output logic                  o_done,
    output logic [31:0]           o_position,
    output logic signed [SSW-1:0] o_step_sum,
    output logic [ISW-1:0]        o_interval_sum,
    output logic [31:0]           o_frequency
);

    localparam int SW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam logic [SW-1:0] LAST_SLOT = SW'(RING_DEPTH - 1);

    logic [1:0]            r_prev;
    logic [31:0]           r_pos;
    logic [31:0]           r_last;
    logic [SW-1:0]         r_slot;
    logic [31:0]           r_wstart;
    logic [31:0]           r_wcnt;
    logic [31:0]           r_held;
    logic signed [SSW-1:0] r_ssum;
    logic [ISW-1:0]        r_isum;
    logic                  r_upd;
    logic                  r_done;
    qdv_pkg::t_step        r_step;
    logic [31:0]           r_ivl;
    logic [31:0]           r_now;
    logic [33:0]           r_rd_data;
    logic                  r_rd_vld;
    logic [RING_DEPTH-1:0] r_vld;
    logic [33:0]           r_mem [RING_DEPTH];

    logic [1:0]            cur;
    qdv_pkg::t_step        step;
    logic signed [SSW-1:0] old_step;
    logic signed [SSW-1:0] new_step;
    logic [31:0]           old_ivl;
    logic [31:0]           elapsed;
    logic signed [SSW-1:0] n_ssum;
    logic [ISW-1:0]        n_isum;

    always_comb begin
        cur      = {i_phase_b, i_phase_a};
        step     = qdv_pkg::STEP_TBL[{r_prev, cur}];
        old_step = r_rd_vld ? {{(SSW-2){r_rd_data[33]}}, r_rd_data[33:32]} : '0;
        old_ivl  = r_rd_vld ? r_rd_data[31:0] : 32'd0;
        new_step = {{(SSW-2){r_step[1]}}, r_step};
        n_ssum   = r_ssum - old_step + new_step;
        n_isum   = r_isum - ISW'(old_ivl) + ISW'(r_ivl);
        elapsed  = r_now - r_wstart;
    end

    always_ff @(posedge i_clk) begin
        if (i_start && step != qdv_pkg::STEP_NONE) begin
            r_rd_data <= r_mem[r_slot];
            r_rd_vld  <= r_vld[r_slot];
            r_step    <= step;
            r_ivl     <= i_now - r_last;
            r_now     <= i_now;
        end
        if (r_upd) begin
            r_mem[r_slot] <= {r_step, r_ivl};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev   <= 2'b00;
            r_pos    <= '0;
            r_last   <= '0;
            r_slot   <= '0;
            r_wstart <= '0;
            r_wcnt   <= '0;
            r_held   <= '0;
            r_ssum   <= '0;
            r_isum   <= '0;
            r_upd    <= 1'b0;
            r_done   <= 1'b0;
            r_vld    <= '0;
        end else begin
            r_done <= 1'b0;
            r_upd  <= 1'b0;
            if (i_start) begin
                r_prev <= cur;
                r_last <= i_now;
                if (step != qdv_pkg::STEP_NONE) begin
                    r_upd <= 1'b1;
                end else begin
                    r_done <= 1'b1;
                end
            end
            if (r_upd) begin
                r_pos         <= r_pos + {{30{r_step[1]}}, r_step};
                r_ssum        <= n_ssum;
                r_isum        <= n_isum;
                r_vld[r_slot] <= 1'b1;
                r_slot        <= (r_slot == LAST_SLOT) ? '0 : r_slot + 1'b1;
                if (elapsed >= qdv_pkg::WINDOW_MS) begin
                    r_held   <= r_wcnt;
                    r_wcnt   <= 32'd1;
                    r_wstart <= r_now;
                end else if (r_wcnt != '1) begin
                    r_wcnt <= r_wcnt + 32'd1;
                end
                r_done <= 1'b1;
            end
        end
    end

    assign o_done         = r_done;
    assign o_position     = r_pos;
    assign o_step_sum     = r_ssum;
    assign o_interval_sum = r_isum;
    assign o_frequency    = r_held;

endmodule

// ===== rtl/qdv_smul.sv =====
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
module qdv_smul #(
    parameter int AW = 36,
    parameter int BW = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_go,
    input  logic [AW-1:0]    i_a,
    input  logic [BW-1:0]    i_b,
    output logic             o_done,
    output logic [AW+BW-1:0] o_prod
);

    localparam int CW = $clog2(BW + 1);

    logic             r_busy;
    logic             r_done;
    logic [CW-1:0]    r_cnt;
    logic [AW-1:0]    r_a;
    logic [AW+BW-1:0] r_p;
    logic [AW:0]      n_hi;

    assign n_hi = {1'b0, r_p[AW+BW-1:BW]} + (r_p[0] ? {1'b0, r_a} : '0);

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_a <= i_a;
            r_p <= {{AW{1'b0}}, i_b};
        end else if (r_busy) begin
            r_p <= {n_hi, r_p[BW-1:1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(BW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_p;

endmodule

// ===== rtl/qdv_sdiv.sv =====
// Restoring divider, one quotient bit per cycle, low quotient bits plus overflow flag.
module qdv_sdiv #(
    parameter int W = 68
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_go,
    input  logic [W-1:0]           i_num,
    input  logic [W-1:0]           i_den,
    output logic                   o_done,
    output logic [qdv_pkg::QW-1:0] o_quo,
    output logic                   o_ovf
);

    localparam int CW = $clog2(W + 1);

    logic                   r_busy;
    logic                   r_done;
    logic [CW-1:0]          r_cnt;
    logic [W-1:0]           r_n;
    logic [W-1:0]           r_d;
    logic [W-1:0]           r_r;
    logic [qdv_pkg::QW-1:0] r_q;
    logic                   r_ovf;
    logic [W:0]             trial;
    logic [W:0]             diff;
    logic                   ge;

    always_comb begin
        trial = {r_r, r_n[W-1]};
        diff  = trial - {1'b0, r_d};
        ge    = trial >= {1'b0, r_d};
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_n   <= i_num;
            r_d   <= i_den;
            r_r   <= '0;
            r_q   <= '0;
            r_ovf <= 1'b0;
        end else if (r_busy) begin
            r_n   <= {r_n[W-2:0], 1'b0};
            r_r   <= ge ? diff[W-1:0] : trial[W-1:0];
            r_q   <= {r_q[qdv_pkg::QW-2:0], ge};
            r_ovf <= r_ovf | r_q[qdv_pkg::QW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;
    assign o_ovf  = r_ovf;

endmodule

// ===== rtl/quadrature_decoder_velocity.sv =====
// Top level: x4 quadrature decoder with averaged velocity, distance and frequency.
//
//  channel  direction  payload (lowest bit first)
//  s_axis   in         phase_a_level, phase_b_level, now_ms
//  m_axis   out        count_position, velocity_q16, distance_q16, frequency_q2
//  cfg      in         i_cfg_index (0 pitch_q16, 1 counts_per_unit), i_cfg_data
//
//  One word at a time: a new word is taken only in idle, after the previous one has
//  passed track, three bit-serial products, two restoring quotients over the 68-bit
//  product at RING_DEPTH 8, and output.
//  A zero interval sum skips the velocity path.
//  Reset is synchronous, active low; ring entries read as zero until written.
//  A finished word waits in the output register while the next word is taken.
module quadrature_decoder_velocity #(
    parameter int RING_DEPTH = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [39:0]  s_axis_tdata,   // phase_a_level, phase_b_level, now_ms[33:2], zero pad
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata,   // count_position, velocity_q16, distance_q16,
                                         // frequency_q2
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [qdv_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]  i_cfg_data
);

    localparam int SSW = $clog2(RING_DEPTH + 1) + 2;
    localparam int ISW = 32 + $clog2(RING_DEPTH + 1);
    localparam int PW  = ISW + 32;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_TRACK  = 3'd1;
    localparam logic [2:0] S_MUL_DV = 3'd2;
    localparam logic [2:0] S_MUL_NV = 3'd3;
    localparam logic [2:0] S_DIV_V  = 3'd4;
    localparam logic [2:0] S_MUL_D  = 3'd5;
    localparam logic [2:0] S_DIV_D  = 3'd6;
    localparam logic [2:0] S_OUT    = 3'd7;

    logic [2:0]     r_state;
    logic [31:0]    r_pitch;
    logic [15:0]    r_cpu;
    logic           r_mul_go;
    logic           r_div_go;
    logic [PW-1:0]  r_den;
    logic [31:0]    r_vel;
    logic [31:0]    r_dist;
    logic           r_out_valid;
    logic [127:0]   r_out_data;

    logic                  in_acc;
    logic                  trk_done;
    logic [31:0]           trk_pos;
    logic signed [SSW-1:0] trk_ssum;
    logic [ISW-1:0]        trk_isum;
    logic [31:0]           trk_freq;

    logic                  mul_done;
    logic [PW-1:0]         mul_prod;
    logic [ISW-1:0]        mul_a;
    logic [31:0]           mul_b;
    logic                  div_done;
    logic [qdv_pkg::QW-1:0] div_quo;
    logic                  div_ovf;
    logic [PW-1:0]         div_den;

    logic [15:0]           cpu_eff;
    logic                  vneg;
    logic [SSW-1:0]        smag;
    logic [ISW-1:0]        vmul;
    logic                  dneg;
    logic [31:0]           dmag;
    logic [31:0]           sat_res;
    logic                  sat_neg;

    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    always_comb begin
        cpu_eff = (r_cpu == 16'd0) ? 16'd1 : r_cpu;
        vneg    = trk_ssum < 0;
        smag    = vneg ? SSW'(-trk_ssum) : SSW'(trk_ssum);
        // times 1000 = 1024 - 16 - 8
        vmul    = (ISW'(smag) << 10) - (ISW'(smag) << 4) - (ISW'(smag) << 3);
        dneg    = trk_pos[31];
        dmag    = dneg ? (32'd0 - trk_pos) : trk_pos;

        case (r_state)
            S_MUL_DV: begin
                mul_a = trk_isum;
                mul_b = {16'd0, cpu_eff};
            end
            S_MUL_NV: begin
                mul_a = vmul;
                mul_b = r_pitch;
            end
            default: begin
                mul_a = ISW'(dmag);
                mul_b = r_pitch;
            end
        endcase
        div_den = (r_state == S_DIV_V) ? r_den : PW'(cpu_eff);

        // saturate sign and magnitude into 32-bit two's complement
        sat_neg = (r_state == S_DIV_V) ? vneg : dneg;
        if (!sat_neg) begin
            sat_res = (div_ovf || div_quo[32] || div_quo[31]) ? 32'h7FFF_FFFF
                                                              : div_quo[31:0];
        end else begin
            sat_res = (div_ovf || div_quo[32] || (div_quo[31] && div_quo[30:0] != '0))
                      ? 32'h8000_0000 : (32'd0 - div_quo[31:0]);
        end
    end

    qdv_track #(
        .RING_DEPTH(RING_DEPTH),
        .SSW(SSW),
        .ISW(ISW)
    ) u_track (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_start(in_acc),
        .i_phase_a(s_axis_tdata[0]),
        .i_phase_b(s_axis_tdata[1]),
        .i_now(s_axis_tdata[33:2]),
        .o_done(trk_done),
        .o_position(trk_pos),
        .o_step_sum(trk_ssum),
        .o_interval_sum(trk_isum),
        .o_frequency(trk_freq)
    );

    qdv_smul #(
        .AW(ISW),
        .BW(32)
    ) u_smul (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_go(r_mul_go),
        .i_a(mul_a),
        .i_b(mul_b),
        .o_done(mul_done),
        .o_prod(mul_prod)
    );

    qdv_sdiv #(
        .W(PW)
    ) u_sdiv (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_go(r_div_go),
        .i_num(mul_prod),
        .i_den(div_den),
        .o_done(div_done),
        .o_quo(div_quo),
        .o_ovf(div_ovf)
    );

    always_ff @(posedge i_clk) begin
        if (r_state == S_MUL_DV && mul_done) begin
            r_den <= mul_prod;
        end
        if (r_state == S_TRACK && trk_done && trk_isum == '0) begin
            r_vel <= 32'd0;
        end else if (r_state == S_DIV_V && div_done) begin
            r_vel <= sat_res;
        end
        if (r_state == S_DIV_D && div_done) begin
            r_dist <= sat_res;
        end
        if (r_state == S_OUT && (!r_out_valid || m_axis_tready)) begin
            r_out_data <= {trk_freq, r_dist, r_vel, trk_pos};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pitch     <= qdv_pkg::PITCH_RST;
            r_cpu       <= qdv_pkg::CPU_RST;
            r_mul_go    <= 1'b0;
            r_div_go    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_mul_go <= 1'b0;
            r_div_go <= 1'b0;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    qdv_pkg::CFG_PITCH: r_pitch <= i_cfg_data;
                    qdv_pkg::CFG_CPU:   r_cpu   <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (r_out_valid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_state <= S_TRACK;
                    end
                end
                S_TRACK: begin
                    if (trk_done) begin
                        r_mul_go <= 1'b1;
                        r_state  <= (trk_isum == '0) ? S_MUL_D : S_MUL_DV;
                    end
                end
                S_MUL_DV: begin
                    if (mul_done) begin
                        r_mul_go <= 1'b1;
                        r_state  <= S_MUL_NV;
                    end
                end
                S_MUL_NV: begin
                    if (mul_done) begin
                        r_div_go <= 1'b1;
                        r_state  <= S_DIV_V;
                    end
                end
                S_DIV_V: begin
                    if (div_done) begin
                        r_mul_go <= 1'b1;
                        r_state  <= S_MUL_D;
                    end
                end
                S_MUL_D: begin
                    if (mul_done) begin
                        r_div_go <= 1'b1;
                        r_state  <= S_DIV_D;
                    end
                end
                S_DIV_D: begin
                    if (div_done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for quadrature_decoder_velocity: decode, velocity, distance, frequency.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          RING_SIZE    = 8;
    localparam int          IDLE_LIMIT   = 20000;
    localparam int          SETTLE       = 300;
    localparam int          HOLD_CYCLES  = 3000;
    localparam int          REPORT_MAX   = 10;
    localparam logic [31:0] WINDOW_LEN   = 32'd1000;
    localparam logic [7:0]  REG_SPARE    = 8'd2;
    localparam logic [7:0]  REG_TOP      = 8'hFF;

    typedef struct packed {
        logic [31:0] frequency;
        logic [31:0] distance;
        logic [31:0] velocity;
        logic [31:0] position;
    } t_motion;

    logic         i_clk         = 1'b0;
    logic         i_rst_n       = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [39:0]  s_axis_tdata  = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [127:0] m_axis_tdata;
    logic         i_cfg_valid   = 1'b0;
    logic         o_cfg_ready;
    logic [qdv_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [31:0]  i_cfg_data    = '0;

    quadrature_decoder_velocity dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // decoder shadow state
    logic [31:0] pitch_q16;
    logic [31:0] counts_per_rev;
    logic [1:0]  last_phase;
    logic [31:0] position;
    logic [31:0] prev_ms;
    logic [31:0] win_start;
    logic [31:0] win_count;
    logic [31:0] freq_held;
    int          ring_step [RING_SIZE];
    logic [31:0] ring_ms   [RING_SIZE];
    int          ring_pos;
    int          step_total;
    logic [63:0] ms_total;

    t_motion     motion_q [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit hold_req       = 1'b0;
    int hold_left      = 0;

    int samples_sent   = 0;
    int results_seen   = 0;
    int reg_writes     = 0;
    int mismatches     = 0;
    int unexpected     = 0;
    int reports        = 0;
    int quiet_cycles   = 0;

    logic [1:0]  stim_phase;
    logic [31:0] stim_ms;
    bit          stim_fwd;

    function automatic int decode_step(logic [3:0] k);
        case (k)
            4'd1, 4'd7, 4'd8, 4'd14: return -1;
            4'd2, 4'd4, 4'd11, 4'd13: return 1;
            default: return 0;
        endcase
    endfunction

    function automatic logic [1:0] gray_next(logic [1:0] p, bit fwd);
        case (p)
            2'd0: return fwd ? 2'd2 : 2'd1;
            2'd1: return fwd ? 2'd0 : 2'd3;
            2'd2: return fwd ? 2'd3 : 2'd0;
            default: return fwd ? 2'd1 : 2'd2;
        endcase
    endfunction

    function automatic logic [31:0] clamp_signed(bit neg, logic [63:0] mag);
        if (!neg)
            return (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
        if (mag > 64'h8000_0000)
            return 32'h8000_0000;
        return 32'd0 - mag[31:0];
    endfunction

    function automatic void shadow_reset();
        pitch_q16      = qdv_pkg::PITCH_RST;
        counts_per_rev = {16'd0, qdv_pkg::CPU_RST};
        last_phase     = '0;
        position       = '0;
        prev_ms        = '0;
        win_start      = '0;
        win_count      = '0;
        freq_held      = '0;
        ring_pos       = 0;
        step_total     = 0;
        ms_total       = '0;
        for (int i = 0; i < RING_SIZE; i++) begin
            ring_step[i] = 0;
            ring_ms[i]   = '0;
        end
    endfunction

    function automatic void shadow_write(logic [7:0] idx, logic [31:0] data);
        if (idx == qdv_pkg::CFG_PITCH)
            pitch_q16 = data;
        else if (idx == qdv_pkg::CFG_CPU)
            counts_per_rev = {16'd0, data[15:0]};
    endfunction

    function automatic t_motion decode_sample(bit a, bit b, logic [31:0] now);
        logic [1:0]  cur;
        int          step;
        logic [31:0] gap;
        logic [31:0] since;
        logic [63:0] divisor;
        logic [63:0] mag;
        t_motion     r;
        cur  = {b, a};
        step = 0;
        if (cur != last_phase) begin
            step       = decode_step({last_phase, cur});
            last_phase = cur;
        end
        if (step != 0) begin
            gap        = now - prev_ms;
            position   = position + 32'(step);
            step_total = step_total - ring_step[ring_pos] + step;
            ms_total   = ms_total - {32'd0, ring_ms[ring_pos]} + {32'd0, gap};
            ring_step[ring_pos] = step;
            ring_ms[ring_pos]   = gap;
            ring_pos   = (ring_pos + 1) % RING_SIZE;
            since      = now - win_start;
            if (since >= WINDOW_LEN) begin
                freq_held = win_count;
                win_count = '0;
                win_start = now;
            end
            if (win_count != 32'hFFFF_FFFF)
                win_count = win_count + 32'd1;
        end
        prev_ms = now;
        divisor = (counts_per_rev == 0) ? 64'd1 : {32'd0, counts_per_rev};
        r.position  = position;
        r.frequency = freq_held;
        r.velocity  = '0;
        if (ms_total != 0) begin
            mag = (step_total < 0) ? 64'(-step_total) : 64'(step_total);
            r.velocity = clamp_signed(step_total < 0,
                                      (mag * 64'd1000 * {32'd0, pitch_q16}) /
                                      (ms_total * divisor));
        end
        mag = position[31] ? {32'd0, 32'd0 - position} : {32'd0, position};
        r.distance = clamp_signed(position[31], (mag * {32'd0, pitch_q16}) / divisor);
        return r;
    endfunction

    task automatic send_sample(bit a, bit b, logic [31:0] now);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, now, b, a};
        do @(posedge i_clk); while (!s_axis_tready);
        motion_q.push_back(decode_sample(a, b, now));
        samples_sent++;
    endtask

    task automatic write_reg(logic [7:0] idx, logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        shadow_write(idx, data);
        reg_writes++;
    endtask

    // upper half of the count word carries junk that must be dropped
    task automatic set_scaling(logic [31:0] pitch, logic [15:0] counts);
        write_reg(qdv_pkg::CFG_PITCH, pitch);
        write_reg(qdv_pkg::CFG_CPU, {16'($urandom), counts});
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        wait (motion_q.size() == 0);
        @(posedge i_clk);
    endtask

    task automatic send_random(int count);
        int roll;
        for (int n = 0; n < count; n++) begin
            roll = $urandom_range(99);
            if (roll < 75) begin
                if ($urandom_range(15) == 0)
                    stim_fwd = !stim_fwd;
                stim_phase = gray_next(stim_phase, stim_fwd);
                stim_ms += ($urandom_range(9) == 0) ? $urandom_range(3000) : $urandom_range(20);
            end else if (roll < 85) begin
                stim_ms += $urandom_range(5);
            end else if (roll < 93) begin
                stim_phase = stim_phase ^ 2'b11;
                stim_ms += $urandom_range(50);
            end else begin
                stim_phase = 2'($urandom_range(3));
                stim_ms = $urandom_range(1) ? $urandom : stim_ms + $urandom_range(100);
            end
            send_sample(stim_phase[0], stim_phase[1], stim_ms);
        end
    endtask

    // every {prev, cur} pair from reset, timestamps run across the 32-bit wrap
    task automatic test_decode_table();
        logic [1:0]  walk  [16] = '{0, 1, 1, 2, 2, 3, 3, 0, 2, 0, 3, 1, 3, 2, 1, 0};
        logic [31:0] stamp [16] = '{32'd0, 32'd0, 32'd0, 32'd7, 32'd400, 32'd1400,
                                    32'hFFFF_FF00, 32'hFFFF_FFFF, 32'd5, 32'd900,
                                    32'd2100, 32'd2101, 32'd2101, 32'd3500,
                                    32'h8000_0000, 32'h8000_0010};
        for (int k = 0; k < 16; k++)
            send_sample(walk[k][0], walk[k][1], stamp[k]);
        wait_drained();
    endtask

    // extreme scaling: saturation both ways, unused indexes, zero count divisor
    task automatic test_saturation();
        logic [31:0] t;
        t = 32'd50000;
        write_reg(REG_SPARE, 32'hFFFF_FFFF);
        write_reg(REG_TOP, 32'h0000_0000);
        set_scaling(32'hFFFF_FFFF, 16'd1);
        for (int k = 0; k < 5; k++) begin
            stim_phase = gray_next(last_phase, 1'b1);
            t += 1;
            send_sample(stim_phase[0], stim_phase[1], t);
        end
        for (int k = 0; k < 10; k++) begin
            stim_phase = gray_next(last_phase, 1'b0);
            t += 1;
            send_sample(stim_phase[0], stim_phase[1], t);
        end
        wait_drained();
        set_scaling(32'hFFFF_FFFF, 16'd0);
        stim_phase = gray_next(last_phase, 1'b0);
        send_sample(stim_phase[0], stim_phase[1], t + 32'd2);
        wait_drained();
        stim_ms = t + 32'd2;
    endtask

    task automatic test_pacing(int send_pct, int recv_pct, logic [31:0] pitch,
                               logic [15:0] counts, int count);
        wait_drained();
        set_scaling(pitch, counts);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        send_random(count);
        wait_drained();
    endtask

    // output held off long enough for the input side to back up
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req = 1'b1;
        send_random(30);
        wait_drained();
    endtask

    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            if (reports < REPORT_MAX) begin
                reports++;
                $display("mismatch on result %0d, %s: expected %h, got %h",
                         results_seen, name, want, got);
            end
        end
    endtask

    // inputs only move at rising edges, so the handshake seen here is the one at the next edge
    always @(negedge i_clk) begin
        t_motion want;
        t_motion got;
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (i_cfg_valid && o_cfg_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= IDLE_LIMIT) begin
                    $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
                    $display("FAIL");
                    $finish;
                end
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata;
                if (motion_q.size() == 0) begin
                    unexpected++;
                    if (reports < REPORT_MAX) begin
                        reports++;
                        $display("unexpected result %h", m_axis_tdata);
                    end
                end else begin
                    want = motion_q.pop_front();
                    check_field("count_position", want.position, got.position);
                    check_field("velocity_q16", want.velocity, got.velocity);
                    check_field("distance_q16", want.distance, got.distance);
                    check_field("frequency_q2", want.frequency, got.frequency);
                end
                results_seen++;
            end
        end
    end

    initial begin
        int errors;
        shadow_reset();
        stim_phase = '0;
        stim_fwd   = 1'b1;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_decode_table();
        test_saturation();
        test_pacing(0, 0, $urandom, 16'($urandom_range(65535, 1)), 240);
        test_pacing(63, 0, 32'hFFFF_FFFF, 16'd1, 240);
        test_pacing(0, 63, 32'd0, 16'hFFFF, 240);
        test_pacing(25, 25, 32'($urandom_range(32'h0010_0000, 1)),
                    16'($urandom_range(16)), 240);
        test_backpressure();

        repeat (SETTLE) @(posedge i_clk);
        errors = mismatches + unexpected + motion_q.size();
        $display("%0d encoder samples: full decode table, saturation, 4 pacing mixes, hold-off",
                 samples_sent);
        $display("%0d results checked, %0d register writes, %0d mismatches, %0d extra, %0d missing",
                 results_seen, reg_writes, mismatches, unexpected, motion_q.size());
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
